// ===== hw/rtl/quadrature_p_position_control_unit_assert.svh =====
// Assertion macros shared by the quadrature position control RTL.
// Each macro expects signals named clk and rst_n in the including module.
`ifndef QUADRATURE_P_POSITION_CONTROL_UNIT_ASSERT_SVH
`define QUADRATURE_P_POSITION_CONTROL_UNIT_ASSERT_SVH

// A condition that must hold at every clock edge outside reset.
`define QPPC_AST_NOW(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A consequence that must hold in the same cycle as its antecedent.
`define QPPC_AST_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// A consequence that must hold in the cycle after its antecedent.
`define QPPC_AST_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/qppc_pkg.sv =====
// Package for the quadrature position control unit: widths, constants and types.
// Has no dependencies; the out interface, decoder, drive and top level import it.
package qppc_pkg;

  localparam int COUNTS_PER_TURN = 216;
  localparam int COUNT_WIDTH     = 32;

  localparam int REF_W  = 32;
  localparam int GAIN_W = 8;
  localparam int DUTY_W = 8;
  localparam int POS_W  = 32;

  // Configuration port.
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_REF  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PWM  = 2'd2;

  localparam logic signed [REF_W-1:0] REF_RST  = 32'sd2160;
  localparam logic [GAIN_W-1:0]       GAIN_RST = 8'd10;
  localparam logic [DUTY_W-1:0]       PWM_RST  = 8'd100;

  // Error, product and saturation widths.
  localparam int ERR_W  = ((COUNT_WIDTH > REF_W) ? COUNT_WIDTH : REF_W) + 1;
  localparam int PROD_W = ERR_W + GAIN_W;
  localparam int CPT_W  = $clog2(COUNTS_PER_TURN + 1);
  localparam int LIM_W  = DUTY_W + 1 + CPT_W;
  // An unsaturated product is below 2^DUTY_W * COUNTS_PER_TURN.
  localparam int PLO_W  = DUTY_W + CPT_W;

  // Reciprocal of COUNTS_PER_TURN, rounded up. With this shift the error of the
  // scaled product stays below 1/COUNTS_PER_TURN, so the quotient is exact.
  localparam int RECIP_SH = PLO_W + CPT_W + 1;
  localparam int RECIP_W  = RECIP_SH - CPT_W + 2;
  localparam logic [63:0] RECIP_M64 =
    ((64'd1 << RECIP_SH) + 64'(COUNTS_PER_TURN) - 64'd1) / 64'(COUNTS_PER_TURN);
  localparam logic [RECIP_W-1:0] RECIP_M = RECIP_M64[RECIP_W-1:0];
  localparam int QFULL_W = RECIP_W + PLO_W;

  typedef struct packed {
    logic signed [COUNT_WIDTH-1:0] count;
    logic                          qerr;
  } qppc_dec_t;

  typedef struct packed {
    logic ld_s2;
    logic ld_out;
  } qppc_ctl_t;

endpackage

// ===== hw/rtl/qppc_in_if.sv =====
// Input channel of the quadrature position control unit: encoder sample and tick.
// Self-contained; carries valid, ready and the sample fields.
interface qppc_in_if;
  logic valid;
  logic ready;
  logic enc_a;
  logic enc_b;
  logic control_tick;

  modport source (output valid, enc_a, enc_b, control_tick, input ready);
  modport sink   (input valid, enc_a, enc_b, control_tick, output ready);
endinterface

// ===== hw/rtl/qppc_out_if.sv =====
// Result channel of the quadrature position control unit: position, duties, error.
// Depends on qppc_pkg for the field widths.
interface qppc_out_if;
  import qppc_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [POS_W-1:0] position;
  logic [DUTY_W-1:0]       fwd_duty;
  logic [DUTY_W-1:0]       rev_duty;
  logic                    quad_error;

  modport source (output valid, position, fwd_duty, rev_duty, quad_error, input ready);
  modport sink   (input valid, position, fwd_duty, rev_duty, quad_error, output ready);
endinterface

// ===== hw/rtl/qppc_decoder.sv =====
// X4 quadrature decoder: pin history and the position counter.
// Depends on qppc_pkg and the assertion macro header.
module qppc_decoder (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                take,
  input  logic                enc_a,
  input  logic                enc_b,
  output qppc_pkg::qppc_dec_t dec
);
  import qppc_pkg::*;

  logic                          last_a_r;
  logic                          last_b_r;
  logic signed [COUNT_WIDTH-1:0] count_r;
  logic signed [COUNT_WIDTH-1:0] count_nxt;
  logic                          ch_a;
  logic                          ch_b;
  logic                          qerr;

  assign ch_a = enc_a ^ last_a_r;
  assign ch_b = enc_b ^ last_b_r;

  // A lone edge on A counts up when the pins differ; a lone edge on B counts up
  // when they match. Edges on both pins at once are an illegal transition.
  always_comb begin
    count_nxt = count_r;
    qerr      = 1'b0;
    if (ch_a && ch_b) begin
      qerr = 1'b1;
    end else if (ch_a) begin
      count_nxt = (enc_a != enc_b) ? count_r + COUNT_WIDTH'(1) : count_r - COUNT_WIDTH'(1);
    end else if (ch_b) begin
      count_nxt = (enc_a == enc_b) ? count_r + COUNT_WIDTH'(1) : count_r - COUNT_WIDTH'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_a_r <= 1'b0;
      last_b_r <= 1'b0;
      count_r  <= '0;
    end else if (take) begin
      last_a_r <= enc_a;
      last_b_r <= enc_b;
      count_r  <= count_nxt;
    end
  end

  assign dec.count = count_nxt;
  assign dec.qerr  = qerr;

`include "quadrature_p_position_control_unit_assert.svh"

  `QPPC_AST_NEXT(a_qerr_holds_count, take && ch_a && ch_b, count_r == $past(count_r), "count moved on a double edge")
  `QPPC_AST_NEXT(a_idle_holds_count, !take, count_r == $past(count_r), "count moved without a transfer")

endmodule

// ===== hw/rtl/qppc_drive.sv =====
// Proportional drive path: error and gain product, then scaling, saturation and
// the held forward and reverse duties. Depends on qppc_pkg.
module qppc_drive (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  qppc_pkg::qppc_ctl_t                   ctl,
  input  logic signed [qppc_pkg::COUNT_WIDTH-1:0] s1_count,
  input  logic                                  s1_tick,
  input  logic signed [qppc_pkg::REF_W-1:0]     cfg_ref,
  input  logic [qppc_pkg::GAIN_W-1:0]           cfg_gain,
  input  logic [qppc_pkg::DUTY_W-1:0]           cfg_pwm,
  output logic [qppc_pkg::DUTY_W-1:0]           fwd_nxt,
  output logic [qppc_pkg::DUTY_W-1:0]           rev_nxt
);
  import qppc_pkg::*;

  logic signed [ERR_W-1:0] err;
  logic [ERR_W-1:0]        mag;
  logic [PROD_W-1:0]       prod;
  logic [LIM_W-1:0]        limit;
  logic                    sat;

  logic                    s2_sat_r;
  logic [PLO_W-1:0]        s2_plo_r;
  logic                    s2_fwd_r;
  logic                    s2_tick_r;

  logic [QFULL_W-1:0]      q_full;
  logic [DUTY_W-1:0]       drive;
  logic [DUTY_W-1:0]       fwd_hold_r;
  logic [DUTY_W-1:0]       rev_hold_r;

  // First stage: signed error, its magnitude times the gain, and a check of the
  // product against the point where the scaled drive reaches pwm_range + 1.
  always_comb begin
    err   = ERR_W'(cfg_ref) - ERR_W'(s1_count);
    mag   = err[ERR_W-1] ? ERR_W'(-err) : ERR_W'(err);
    prod  = PROD_W'(mag) * PROD_W'(cfg_gain);
    limit = LIM_W'({1'b0, cfg_pwm} + 9'd1) * LIM_W'(COUNTS_PER_TURN);
    sat   = prod >= PROD_W'(limit);
  end

  always_ff @(posedge clk) begin
    if (ctl.ld_s2) begin
      s2_sat_r  <= sat;
      s2_plo_r  <= prod[PLO_W-1:0];
      s2_fwd_r  <= !err[ERR_W-1] && (err != '0);
      s2_tick_r <= s1_tick;
    end
  end

  // Second stage: divide by the counts per turn through the reciprocal.
  always_comb begin
    q_full = QFULL_W'(s2_plo_r) * QFULL_W'(RECIP_M);
    drive  = s2_sat_r ? cfg_pwm : q_full[RECIP_SH +: DUTY_W];
    if (ctl.ld_out && s2_tick_r) begin
      fwd_nxt = s2_fwd_r ? drive : '0;
      rev_nxt = s2_fwd_r ? '0 : drive;
    end else begin
      fwd_nxt = fwd_hold_r;
      rev_nxt = rev_hold_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_hold_r <= '0;
      rev_hold_r <= '0;
    end else begin
      fwd_hold_r <= fwd_nxt;
      rev_hold_r <= rev_nxt;
    end
  end

endmodule

// ===== hw/rtl/quadrature_p_position_control_unit.sv =====
// Top level of the quadrature position control unit: configuration registers,
// pipeline valids and the result register. Depends on qppc_pkg, both channel
// interfaces, qppc_decoder, qppc_drive and the assertion macro header.
//
// The unit decodes an x4 quadrature encoder and runs a proportional position
// loop. Every input transfer carries one sample of pins A and B plus a control
// tick, and produces exactly one result transfer with the updated position,
// the forward and reverse duties, and a flag for an illegal double edge. The
// unit takes one sample per clock cycle while input ready is high; each sample
// passes through the stage-one, stage-two and result registers before its
// result is presented. The rate is set by the position counter in the
// decoder, which updates in the cycle a sample is accepted; the error, gain
// product and constant-divisor scaling follow in two registered stages whose
// order matches the sample order, so a tick always sees the count that
// includes its own sample. Input ready stays high while any of the three
// stages is free, so results waiting at the output do not stop new samples
// until all stages are full. Duties only change on a tick and hold in
// between; the drive is |reference - position| times the gain divided by the
// counts per turn, truncated and clipped at pwm_range. Configuration writes
// take effect at the next clock edge and should be made while no sample is in
// flight.
module quadrature_p_position_control_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  qppc_in_if.sink                           in_if,
  qppc_out_if.source                        out_if,
  input  logic                              cfg_we,
  input  logic [qppc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [qppc_pkg::CFG_W-1:0]        cfg_wdata
);
  import qppc_pkg::*;

  // Configuration registers.
  logic signed [REF_W-1:0] ref_r;
  logic [GAIN_W-1:0]       gain_r;
  logic [DUTY_W-1:0]       pwm_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_r  <= REF_RST;
      gain_r <= GAIN_RST;
      pwm_r  <= PWM_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_REF:  ref_r  <= cfg_wdata[REF_W-1:0];
        CFG_GAIN: gain_r <= cfg_wdata[GAIN_W-1:0];
        CFG_PWM:  pwm_r  <= cfg_wdata[DUTY_W-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline flow control. Each stage loads when it is empty or when its
  // content moves on in the same cycle.
  logic      v1_r, v2_r, ov_r;
  logic      v1_nxt, v2_nxt, ov_nxt;
  logic      ready2;
  logic      take;
  qppc_ctl_t ctl;

  assign ready2     = !v2_r || !ov_r || out_if.ready;
  assign ctl.ld_out = v2_r && (!ov_r || out_if.ready);
  assign ctl.ld_s2  = v1_r && ready2;
  assign in_if.ready = !v1_r || ready2;
  assign take       = in_if.valid && in_if.ready;

  always_comb begin
    v1_nxt = take ? 1'b1 : (ctl.ld_s2 ? 1'b0 : v1_r);
    v2_nxt = ctl.ld_s2 ? 1'b1 : (ctl.ld_out ? 1'b0 : v2_r);
    ov_nxt = ctl.ld_out ? 1'b1 : (out_if.ready ? 1'b0 : ov_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      ov_r <= ov_nxt;
    end
  end

  // Decode stage: the count advances on the transfer itself.
  qppc_dec_t dec;

  qppc_decoder u_decoder (
    .clk   (clk),
    .rst_n (rst_n),
    .take  (take),
    .enc_a (in_if.enc_a),
    .enc_b (in_if.enc_b),
    .dec   (dec)
  );

  logic signed [COUNT_WIDTH-1:0] s1_count_r;
  logic                          s1_qerr_r;
  logic                          s1_tick_r;
  logic signed [COUNT_WIDTH-1:0] s2_count_r;
  logic                          s2_qerr_r;

  always_ff @(posedge clk) begin
    if (take) begin
      s1_count_r <= dec.count;
      s1_qerr_r  <= dec.qerr;
      s1_tick_r  <= in_if.control_tick;
    end
    if (ctl.ld_s2) begin
      s2_count_r <= s1_count_r;
      s2_qerr_r  <= s1_qerr_r;
    end
  end

  // Drive path: two stages alongside the position pipeline.
  logic [DUTY_W-1:0] fwd_nxt;
  logic [DUTY_W-1:0] rev_nxt;

  qppc_drive u_drive (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl),
    .s1_count (s1_count_r),
    .s1_tick  (s1_tick_r),
    .cfg_ref  (ref_r),
    .cfg_gain (gain_r),
    .cfg_pwm  (pwm_r),
    .fwd_nxt  (fwd_nxt),
    .rev_nxt  (rev_nxt)
  );

  // Result register.
  logic signed [POS_W-1:0] out_position_r;
  logic [DUTY_W-1:0]       out_fwd_r;
  logic [DUTY_W-1:0]       out_rev_r;
  logic                    out_qerr_r;

  always_ff @(posedge clk) begin
    if (ctl.ld_out) begin
      out_position_r <= POS_W'(s2_count_r);
      out_fwd_r      <= fwd_nxt;
      out_rev_r      <= rev_nxt;
      out_qerr_r     <= s2_qerr_r;
    end
  end

  assign out_if.valid      = ov_r;
  assign out_if.position   = out_position_r;
  assign out_if.fwd_duty   = out_fwd_r;
  assign out_if.rev_duty   = out_rev_r;
  assign out_if.quad_error = out_qerr_r;

`include "quadrature_p_position_control_unit_assert.svh"

  `QPPC_AST_IMP(a_duty_exclusive, ov_r, (out_fwd_r == '0) || (out_rev_r == '0),
                "both duties are nonzero")
  `QPPC_AST_IMP(a_stall_only_full, !in_if.ready, v1_r && v2_r && ov_r && !out_if.ready,
                "input stalled with a free stage")
  `QPPC_AST_NEXT(a_result_follows, ctl.ld_out, ov_r, "loaded result not presented")

endmodule
